// ----- hdl/ppa_pkg.sv -----
// Package for the photometric pixel augment unit: field widths, register codes,
// request type and the function for the constant exp2 table entries. No dependencies.
`default_nettype none

package ppa_pkg;

    localparam int DATA_W   = 16;
    localparam int CHAN_W   = 2;
    localparam int GAIN_W   = 15;
    localparam int ADDR_W   = 4;
    localparam int PDATA_W  = 32;
    localparam int LOG_BITS = 24;
    localparam int MANT_W   = 31;
    localparam int SHIFT_W  = 6;
    localparam int RND_W    = 63;
    localparam int NUM_REGS = 3;

    localparam logic [1:0] REG_MEAN_RED   = 2'd0;
    localparam logic [1:0] REG_MEAN_GREEN = 2'd1;
    localparam logic [1:0] REG_MEAN_BLUE  = 2'd2;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = -16'sh8000;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [MANT_W-1:0]        t_mant;

    typedef struct packed {
        t_sample             pixel_in;
        logic [CHAN_W-1:0]   channel;
        t_sample             contrast_offset;
        t_sample             brightness;
        logic [GAIN_W-1:0]   colour_gain;
        logic [GAIN_W-1:0]   gamma_value;
        t_sample             noise_sample;
    } t_req;

    typedef struct packed {
        logic special;
        logic is_one;
    } t_spec;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Q1.30 value of 2^(-2^-k)
    function automatic t_mant exp_entry(input int k);
        logic [63:0] t;
        t = 64'd1 << 29;
        for (int j = 1; j <= k; j++) begin
            t = isqrt64(t << 30);
        end
        return t[MANT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ppa_in_if.sv -----
// Request channel of the photometric pixel augment unit.
// Depends on ppa_pkg.
`default_nettype none

interface ppa_in_if;
    import ppa_pkg::*;

    logic                valid;
    logic                ready;
    t_sample             pixel_in;
    logic [CHAN_W-1:0]   channel;
    t_sample             contrast_offset;
    t_sample             brightness;
    logic [GAIN_W-1:0]   colour_gain;
    logic [GAIN_W-1:0]   gamma_value;
    t_sample             noise_sample;

    modport source (
        output valid, pixel_in, channel, contrast_offset, brightness,
               colour_gain, gamma_value, noise_sample,
        input  ready
    );
    modport sink (
        input  valid, pixel_in, channel, contrast_offset, brightness,
               colour_gain, gamma_value, noise_sample,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/ppa_out_if.sv -----
// Result channel of the photometric pixel augment unit.
// Depends on ppa_pkg.
`default_nettype none

interface ppa_out_if;
    import ppa_pkg::*;

    logic    valid;
    logic    ready;
    t_sample pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink   (input valid, pixel_out, output ready);
endinterface

`default_nettype wire

// ----- hdl/ppa_gamma_pipe.sv -----
// Pipelined y^(1/gamma): log2 by squaring stages, bit-per-stage divider, exp2 stages.
// Depends on ppa_pkg.
`default_nettype none

module ppa_gamma_pipe #(
    parameter int FRAC_BITS = 12,
    parameter int SB_W      = 18
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [FRAC_BITS:0]          i_y,
    input  logic [ppa_pkg::GAIN_W-1:0]  i_gamma,
    input  logic [SB_W-1:0]             i_sb,
    output logic                        o_valid,
    output logic [FRAC_BITS:0]          o_pow,
    output logic [SB_W-1:0]             o_sb
);
    import ppa_pkg::*;

    localparam int PW   = $clog2(FRAC_BITS);
    localparam int KW   = $clog2(FRAC_BITS + 1);
    localparam int MAGW = KW + LOG_BITS;
    localparam int DW   = MAGW + FRAC_BITS + 1;
    localparam int QW   = DW - LOG_BITS;

    // log2 stages
    t_mant               r_lm   [0:LOG_BITS];
    logic [LOG_BITS-1:0] r_lf   [0:LOG_BITS];
    logic [PW-1:0]       r_lp   [0:LOG_BITS];
    logic [GAIN_W-1:0]   r_lg   [0:LOG_BITS];
    logic [SB_W-1:0]     r_lsb  [0:LOG_BITS];
    t_spec               r_lspec[0:LOG_BITS];
    logic                r_lv   [0:LOG_BITS];

    logic [PW-1:0] n_p;
    t_mant         n_m;
    t_spec         n_spec;

    always_comb begin
        n_p = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (i_y[i]) begin
                n_p = PW'(i);
            end
        end
        n_m = MANT_W'(i_y[FRAC_BITS-1:0]) << (MANT_W - 1 - int'(n_p));
        n_spec.special = (i_y == '0) || i_y[FRAC_BITS];
        n_spec.is_one  = i_y[FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv[0] <= 1'b0;
        end else if (i_en) begin
            r_lv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lm[0]    <= n_m;
            r_lf[0]    <= '0;
            r_lp[0]    <= n_p;
            r_lg[0]    <= i_gamma;
            r_lsb[0]   <= i_sb;
            r_lspec[0] <= n_spec;
        end
    end

    for (genvar k = 1; k <= LOG_BITS; k++) begin : g_log
        logic [2*MANT_W-1:0] w_sq;
        logic [MANT_W:0]     w_t;

        assign w_sq = r_lm[k-1] * r_lm[k-1];
        assign w_t  = w_sq[2*MANT_W-1:MANT_W-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lv[k] <= 1'b0;
            end else if (i_en) begin
                r_lv[k] <= r_lv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lm[k]    <= w_t[MANT_W] ? w_t[MANT_W:1] : w_t[MANT_W-1:0];
                r_lf[k]    <= {r_lf[k-1][LOG_BITS-2:0], w_t[MANT_W]};
                r_lp[k]    <= r_lp[k-1];
                r_lg[k]    <= r_lg[k-1];
                r_lsb[k]   <= r_lsb[k-1];
                r_lspec[k] <= r_lspec[k-1];
            end
        end
    end

    // divider stages
    logic [DW-1:0]     r_dq   [0:DW];
    logic [GAIN_W-1:0] r_dr   [0:DW];
    logic [GAIN_W-1:0] r_dg   [0:DW];
    logic [SB_W-1:0]   r_dsb  [0:DW];
    t_spec             r_dspec[0:DW];
    logic              r_dv   [0:DW];

    logic [KW-1:0]   w_kval;
    logic [MAGW-1:0] w_mag;
    logic [DW-1:0]   w_dividend;

    assign w_kval     = KW'(FRAC_BITS) - KW'(r_lp[LOG_BITS]);
    assign w_mag      = {w_kval, {LOG_BITS{1'b0}}} - MAGW'(r_lf[LOG_BITS]);
    assign w_dividend = (DW'(w_mag) << FRAC_BITS) + DW'(r_lg[LOG_BITS] >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_lv[LOG_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dq[0]    <= w_dividend;
            r_dr[0]    <= '0;
            r_dg[0]    <= r_lg[LOG_BITS];
            r_dsb[0]   <= r_lsb[LOG_BITS];
            r_dspec[0] <= r_lspec[LOG_BITS];
        end
    end

    for (genvar j = 1; j <= DW; j++) begin : g_div
        logic [GAIN_W:0] w_t;
        logic [GAIN_W:0] w_diff;
        logic            w_ge;

        assign w_t    = {r_dr[j-1], r_dq[j-1][DW-1]};
        assign w_ge   = w_t >= {1'b0, r_dg[j-1]};
        assign w_diff = w_t - {1'b0, r_dg[j-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else if (i_en) begin
                r_dv[j] <= r_dv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[j]    <= {r_dq[j-1][DW-2:0], w_ge};
                r_dr[j]    <= w_ge ? w_diff[GAIN_W-1:0] : w_t[GAIN_W-1:0];
                r_dg[j]    <= r_dg[j-1];
                r_dsb[j]   <= r_dsb[j-1];
                r_dspec[j] <= r_dspec[j-1];
            end
        end
    end

    // exp2 stages
    t_mant               r_er   [0:LOG_BITS];
    logic [LOG_BITS-1:0] r_efr  [0:LOG_BITS];
    logic                r_ebig [0:LOG_BITS];
    logic [SHIFT_W-1:0]  r_esh  [0:LOG_BITS];
    logic [SB_W-1:0]     r_esb  [0:LOG_BITS];
    t_spec               r_espec[0:LOG_BITS];
    logic                r_ev   [0:LOG_BITS];

    logic [QW-1:0] w_q;

    assign w_q = r_dq[DW][DW-1:LOG_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev[0] <= 1'b0;
        end else if (i_en) begin
            r_ev[0] <= r_dv[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_er[0]    <= MANT_W'(1) << (MANT_W - 1);
            r_efr[0]   <= r_dq[DW][LOG_BITS-1:0];
            r_ebig[0]  <= w_q >= QW'(32 + FRAC_BITS);
            r_esh[0]   <= w_q[SHIFT_W-1:0] + SHIFT_W'(30 - FRAC_BITS);
            r_esb[0]   <= r_dsb[DW];
            r_espec[0] <= r_dspec[DW];
        end
    end

    for (genvar k = 1; k <= LOG_BITS; k++) begin : g_exp
        localparam t_mant TAB = exp_entry(k);
        logic [2*MANT_W-1:0] w_prod;
        logic [2*MANT_W-1:0] w_rnd;

        assign w_prod = r_er[k-1] * TAB;
        assign w_rnd  = w_prod + ((2*MANT_W)'(1) << (MANT_W - 2));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ev[k] <= 1'b0;
            end else if (i_en) begin
                r_ev[k] <= r_ev[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_er[k]    <= r_efr[k-1][LOG_BITS-k] ? w_rnd[2*MANT_W-2:MANT_W-1]
                                                     : r_er[k-1];
                r_efr[k]   <= r_efr[k-1];
                r_ebig[k]  <= r_ebig[k-1];
                r_esh[k]   <= r_esh[k-1];
                r_esb[k]   <= r_esb[k-1];
                r_espec[k] <= r_espec[k-1];
            end
        end
    end

    // final shift and round
    logic [RND_W-1:0]   w_wide;
    logic [RND_W-1:0]   w_shr;
    logic [FRAC_BITS:0] n_pow;
    logic [FRAC_BITS:0] r_pow;
    logic [SB_W-1:0]    r_psb;
    logic               r_pv;

    assign w_wide = RND_W'(r_er[LOG_BITS])
                  + (RND_W'(1) << (r_esh[LOG_BITS] - SHIFT_W'(1)));
    assign w_shr  = w_wide >> r_esh[LOG_BITS];

    always_comb begin
        if (r_espec[LOG_BITS].special) begin
            n_pow = r_espec[LOG_BITS].is_one ? ((FRAC_BITS+1)'(1) << FRAC_BITS) : '0;
        end else if (r_ebig[LOG_BITS]) begin
            n_pow = '0;
        end else begin
            n_pow = w_shr[FRAC_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= r_ev[LOG_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pow <= n_pow;
            r_psb <= r_esb[LOG_BITS];
        end
    end

    assign o_valid = r_pv;
    assign o_pow   = r_pow;
    assign o_sb    = r_psb;

endmodule

`default_nettype wire

// ----- hdl/photometric_pixel_augment_unit.sv -----
// Photometric pixel augment unit: contrast, brightness and colour gain, clamp to [0,1],
// gamma power, noise and per-channel mean removal, saturated to signed Q4.12.
// Takes one sample per clock while the result is not stalled; a stalled result holds the
// pipeline while a skid register still takes one more request. The pipeline holds the 24
// squaring stages of the log2, the one-bit-per-stage quotient pipeline of the exponent and
// the 24 multiply stages of the exp2.
// Depends on ppa_pkg, ppa_in_if, ppa_out_if and ppa_gamma_pipe.
`default_nettype none

module photometric_pixel_augment_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ppa_in_if.sink                        i_pix,
    ppa_out_if.source                     o_pix,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppa_pkg::ADDR_W-1:0]    paddr,
    input  logic [ppa_pkg::PDATA_W-1:0]   pwdata,
    output logic [ppa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import ppa_pkg::*;

    localparam int CW   = ((FRAC_BITS + 1) > DATA_W ? FRAC_BITS + 1 : DATA_W) + 1;
    localparam int PRW  = CW + DATA_W;
    localparam int V0W  = (PRW > DATA_W + FRAC_BITS ? PRW : DATA_W + FRAC_BITS) + 1;
    localparam int VW   = V0W + GAIN_W + 1;
    localparam int CLW  = VW > 3 * FRAC_BITS + 2 ? VW : 3 * FRAC_BITS + 2;
    localparam int SB_W = DATA_W + CHAN_W;
    localparam int SW   = ((FRAC_BITS + 2) > DATA_W + 1 ? FRAC_BITS + 2 : DATA_W + 1) + 2;

    localparam logic signed [CW-1:0]  ONE_C  = CW'(1) <<< FRAC_BITS;
    localparam logic signed [CLW-1:0] TOP_C  = CLW'(1) <<< (3 * FRAC_BITS);
    localparam logic [CLW-1:0]        HALF_C = CLW'(1) << (2 * FRAC_BITS - 1);

    // configuration
    t_sample r_mean [0:NUM_REGS-1];
    logic    w_wr;

    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_mean[i] <= '0;
            end
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_MEAN_RED:   r_mean[0] <= pwdata[DATA_W-1:0];
                REG_MEAN_GREEN: r_mean[1] <= pwdata[DATA_W-1:0];
                REG_MEAN_BLUE:  r_mean[2] <= pwdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MEAN_RED:   prdata = PDATA_W'(r_mean[0]);
            REG_MEAN_GREEN: prdata = PDATA_W'(r_mean[1]);
            REG_MEAN_BLUE:  prdata = PDATA_W'(r_mean[2]);
            default:        prdata = '0;
        endcase
    end

    // input skid and global advance
    t_req r_skid;
    t_req w_in;
    t_req w_src;
    logic r_skid_v;
    logic w_src_v;
    logic w_en;
    logic r_out_v;

    assign w_in.pixel_in        = i_pix.pixel_in;
    assign w_in.channel         = i_pix.channel;
    assign w_in.contrast_offset = i_pix.contrast_offset;
    assign w_in.brightness      = i_pix.brightness;
    assign w_in.colour_gain     = i_pix.colour_gain;
    assign w_in.gamma_value     = i_pix.gamma_value;
    assign w_in.noise_sample    = i_pix.noise_sample;

    assign w_en        = !r_out_v || o_pix.ready;
    assign i_pix.ready = i_rst_n && !r_skid_v;
    assign w_src       = r_skid_v ? r_skid : w_in;
    assign w_src_v     = r_skid_v || i_pix.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (w_en) begin
            r_skid_v <= 1'b0;
        end else if (i_pix.valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && !r_skid_v) begin
            r_skid <= w_in;
        end
    end

    // stage 1: contrast product
    logic signed [PRW-1:0] r1_prod;
    t_sample               r1_bri;
    logic [GAIN_W-1:0]     r1_gain;
    logic [GAIN_W-1:0]     r1_gam;
    logic [SB_W-1:0]       r1_sb;
    logic                  r1_v;

    // stage 2: brightness
    logic signed [V0W-1:0] r2_v0;
    logic [GAIN_W-1:0]     r2_gain;
    logic [GAIN_W-1:0]     r2_gam;
    logic [SB_W-1:0]       r2_sb;
    logic                  r2_v;

    // stage 3: colour gain
    logic signed [VW-1:0]  r3_v;
    logic [GAIN_W-1:0]     r3_gam;
    logic [SB_W-1:0]       r3_sb;
    logic                  r3_v_q;

    // stage 4: clamp and round
    logic [FRAC_BITS:0]    r4_y;
    logic [GAIN_W-1:0]     r4_gam;
    logic [SB_W-1:0]       r4_sb;
    logic                  r4_v;

    logic signed [CW-1:0]  w_scale;
    logic signed [CLW-1:0] w_ve;
    logic signed [CLW-1:0] w_vc;
    logic [CLW-1:0]        w_yr;

    assign w_scale = CW'(w_src.contrast_offset) + ONE_C;
    assign w_ve    = CLW'(r3_v);
    assign w_vc    = (w_ve < 0) ? '0 : ((w_ve > TOP_C) ? TOP_C : w_ve);
    assign w_yr    = $unsigned(w_vc) + HALF_C;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v_q <= 1'b0;
            r4_v   <= 1'b0;
        end else if (w_en) begin
            r1_v   <= w_src_v;
            r2_v   <= r1_v;
            r3_v_q <= r2_v;
            r4_v   <= r3_v_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_prod <= PRW'(w_scale) * PRW'(w_src.pixel_in);
            r1_bri  <= w_src.brightness;
            r1_gain <= w_src.colour_gain;
            r1_gam  <= (w_src.gamma_value == '0) ? GAIN_W'(1) : w_src.gamma_value;
            r1_sb   <= {w_src.noise_sample, w_src.channel};

            r2_v0   <= V0W'(r1_prod) + (V0W'(r1_bri) <<< FRAC_BITS);
            r2_gain <= r1_gain;
            r2_gam  <= r1_gam;
            r2_sb   <= r1_sb;

            r3_v    <= VW'(r2_v0) * VW'($signed({1'b0, r2_gain}));
            r3_gam  <= r2_gam;
            r3_sb   <= r2_sb;

            r4_y    <= w_yr[2*FRAC_BITS +: FRAC_BITS+1];
            r4_gam  <= r3_gam;
            r4_sb   <= r3_sb;
        end
    end

    // gamma power
    logic               w_pv;
    logic [FRAC_BITS:0] w_pow;
    logic [SB_W-1:0]    w_psb;

    ppa_gamma_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (SB_W)
    ) u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_y     (r4_y),
        .i_gamma (r4_gam),
        .i_sb    (r4_sb),
        .o_valid (w_pv),
        .o_pow   (w_pow),
        .o_sb    (w_psb)
    );

    // noise, mean and saturation
    t_sample              w_mean;
    t_sample              w_noise;
    logic signed [SW-1:0] w_res;
    t_sample              n_out;
    t_sample              r_out;

    assign w_noise = w_psb[SB_W-1:CHAN_W];

    always_comb begin
        unique case (w_psb[CHAN_W-1:0])
            REG_MEAN_RED:   w_mean = r_mean[0];
            REG_MEAN_GREEN: w_mean = r_mean[1];
            REG_MEAN_BLUE:  w_mean = r_mean[2];
            default:        w_mean = '0;
        endcase
    end

    assign w_res = SW'($signed({1'b0, w_pow})) + SW'(w_noise) - SW'(w_mean);

    always_comb begin
        if (w_res > SW'(SAT_MAX)) begin
            n_out = SAT_MAX;
        end else if (w_res < SW'(SAT_MIN)) begin
            n_out = SAT_MIN;
        end else begin
            n_out = w_res[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid     = r_out_v;
    assign o_pix.pixel_out = r_out;

    // checks
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !w_en) |=> r_skid_v)
        else $error("skid request dropped during stall");

    a_skid_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && !w_en) |=> r_skid_v)
        else $error("request accepted during stall not held in skid");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r1_v) && $stable(r4_v)))
        else $error("pipeline advanced during stall");

    a_mean_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && paddr[3:2] == REG_MEAN_RED) |=> (r_mean[0] == $past(pwdata[DATA_W-1:0])))
        else $error("mean_red write lost");

endmodule

`default_nettype wire

// ----- sim/photometric_pixel_augment_unit_test.sv -----
// Self-checking testbench for photometric_pixel_augment_unit: directed and random pixel
// requests under random stalls, mean registers written over APB, results checked in order.
// Depends on ppa_pkg, ppa_in_if, ppa_out_if and the unit itself.
`default_nettype none

module photometric_pixel_augment_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ppa_pkg::*;

    localparam int FRAC = 12;
    localparam int SETTLE = 90;

    typedef struct {
        t_req          req;
        bit            typed;
        logic [15:0]   value;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    ppa_in_if  pix_in();
    ppa_out_if pix_out();

    photometric_pixel_augment_unit #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_in), .o_pix(pix_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [63:0]          exp2_frac [1:LOG_BITS];
    logic signed [15:0]   chan_mean [0:2];
    logic [15:0]          pending_pixels[$];
    int                   send_idle_pct, recv_idle_pct;
    bit                   hold_off;
    int                   error_count, requests_sent, results_seen;

    function automatic logic [63:0] root64(input logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] raise_gamma(input logic [63:0] y, input logic [63:0] g);
        logic [63:0] m, f, mag, a, q, fr, r, s;
        int p;
        f = 0;
        p = 0;
        if (y == 0) return 0;
        if (y >= (64'd1 << FRAC)) return 64'd1 << FRAC;
        while ((y >> (p + 1)) != 0) p++;
        m = y << (30 - p);
        for (int k = 0; k < LOG_BITS; k++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd1 << 31)) begin
                f = f | 1;
                m = m >> 1;
            end
        end
        mag = (64'(FRAC - p) << LOG_BITS) - f;
        a = ((mag << FRAC) + g / 2) / g;
        q = a >> LOG_BITS;
        fr = a & ((64'd1 << LOG_BITS) - 1);
        r = 64'd1 << 30;
        for (int k = 1; k <= LOG_BITS; k++) begin
            if (fr[LOG_BITS - k]) r = (r * exp2_frac[k] + (64'd1 << 29)) >> 30;
        end
        s = q + 30 - FRAC;
        if (s >= 62) return 0;
        return (r + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic [15:0] augment_pixel(input t_req rq);
        longint one, v, top, res, mean;
        logic [63:0] y, g;
        one = longint'(1) << FRAC;
        top = longint'(1) << (3 * FRAC);
        g = (rq.gamma_value == 0) ? 64'd1 : 64'(rq.gamma_value);
        v = ((longint'(rq.contrast_offset) + one) * longint'(rq.pixel_in)
             + longint'(rq.brightness) * one) * longint'(rq.colour_gain);
        if (v < 0) v = 0;
        if (v > top) v = top;
        y = (64'(v) + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
        mean = (rq.channel < 3) ? longint'(chan_mean[rq.channel]) : 0;
        res = longint'(raise_gamma(y, g)) + longint'(rq.noise_sample) - mean;
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[15:0];
    endfunction

    function automatic t_req random_request();
        t_req rq;
        rq = {$urandom, $urandom, $urandom};
        if ($urandom_range(99) < 75) begin
            rq.pixel_in        = 16'($urandom_range(4608));
            rq.contrast_offset = 16'(int'($urandom_range(4096)) - 2048);
            rq.brightness      = 16'(int'($urandom_range(2048)) - 1024);
            rq.colour_gain     = 15'($urandom_range(8192, 2048));
            rq.gamma_value     = 15'($urandom_range(16384, 1));
            rq.noise_sample    = 16'(int'($urandom_range(512)) - 256);
        end
        return rq;
    endfunction

    task automatic write_mean(input logic [1:0] idx, input logic signed [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        chan_mean[idx] = value;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_request(input t_req rq, input bit typed, input logic [15:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid           <= 1'b1;
        pix_in.pixel_in        <= rq.pixel_in;
        pix_in.channel         <= rq.channel;
        pix_in.contrast_offset <= rq.contrast_offset;
        pix_in.brightness      <= rq.brightness;
        pix_in.colour_gain     <= rq.colour_gain;
        pix_in.gamma_value     <= rq.gamma_value;
        pix_in.noise_sample    <= rq.noise_sample;
        do @(posedge i_clk); while (!pix_in.ready);
        pending_pixels.insert(pending_pixels.size(), typed ? value : augment_pixel(rq));
        requests_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) send_request(random_request(), 1'b0, '0);
        drain();
    endtask

    // drive the result side; hold off for a long stretch on request
    initial begin
        int held;
        pix_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                pix_out.ready <= 1'b0;
                held = 0;
                while (held < 300) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_off = 1'b0;
            end
            pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            results_seen++;
            if (pending_pixels.size() == 0) begin
                $error("pixel_out: unexpected result %0d", $signed(pix_out.pixel_out));
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (pix_out.pixel_out !== want) begin
                    $error("pixel_out: expected %0d, got %0d", $signed(want),
                           $signed(pix_out.pixel_out));
                    error_count++;
                end
            end
        end
    end

    initial begin
        #400us;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_req base;
        exp2_frac[1] = root64((64'd1 << 29) << 30);
        for (int k = 2; k <= LOG_BITS; k++) exp2_frac[k] = root64(exp2_frac[k - 1] << 30);
        for (int i = 0; i < 3; i++) chan_mean[i] = '0;
        send_idle_pct = 23;
        recv_idle_pct = 55;
        hold_off = 1'b0;
        error_count = 0;
        requests_sent = 0;
        results_seen = 0;
        pix_in.valid = 1'b0;
        pix_in.pixel_in = '0; pix_in.channel = '0; pix_in.contrast_offset = '0;
        pix_in.brightness = '0; pix_in.colour_gain = '0; pix_in.gamma_value = '0;
        pix_in.noise_sample = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unity pixel through unity gain: x = 1, contrast 1, no brightness
        base = '{16'sd4096, 2'd0, 16'sd0, 16'sd0, 15'd4096, 15'd4096, 16'sd0};
        rows.insert(rows.size(), t_row'{base, 1'b1, 16'd4096});
        base.noise_sample = 16'sh7FFF;
        rows.insert(rows.size(), t_row'{base, 1'b1, 16'h7FFF});
        base.pixel_in = 16'sd0; base.noise_sample = -16'sh8000;
        rows.insert(rows.size(), t_row'{base, 1'b1, 16'h8000});
        base.noise_sample = 16'sd0; base.channel = 2'd3;
        rows.insert(rows.size(), t_row'{base, 1'b1, 16'd0});
        base.pixel_in = 16'sh7FFF; base.contrast_offset = 16'sh7FFF;
        rows.insert(rows.size(), t_row'{base, 1'b1, 16'd4096});
        base.pixel_in = -16'sh8000;
        rows.insert(rows.size(), t_row'{base, 1'b1, 16'd0});
        base.brightness = 16'sh7FFF; base.colour_gain = 15'h7FFF;
        rows.insert(rows.size(), t_row'{base, 1'b1, 16'd0});
        base.colour_gain = 15'd0;
        rows.insert(rows.size(), t_row'{base, 1'b1, 16'd0});
        for (int i = 0; i < 16; i++) begin
            base = '{16'(i * 256 + 1), 2'(i), 16'sd0, 16'(i * 37), 15'd4096,
                     15'(i * 1024), 16'(i - 8)};
            if (i == 0) base.gamma_value = 15'h7FFF;
            if (i == 1) base.gamma_value = 15'd1;
            if (i == 2) base.contrast_offset = -16'sh8000;
            if (i == 3) base.contrast_offset = -16'sd4096;
            rows.insert(rows.size(), t_row'{base, 1'b0, '0});
        end
        foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].value);
        drain();

        write_mean(REG_MEAN_RED, 16'sh7FFF);
        write_mean(REG_MEAN_GREEN, -16'sh8000);
        write_mean(REG_MEAN_BLUE, 16'sd1234);
        random_phase(180);

        send_idle_pct = 55;
        recv_idle_pct = 23;
        write_mean(REG_MEAN_RED, -16'sd2048);
        write_mean(REG_MEAN_GREEN, 16'sd512);
        write_mean(REG_MEAN_BLUE, -16'sh8000);
        hold_off = 1'b1;
        send_idle_pct = 0;
        random_phase(150);

        send_idle_pct = 55;
        random_phase(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mean(REG_MEAN_RED, 16'(int'($urandom)));
        write_mean(REG_MEAN_GREEN, 16'sh7FFF);
        write_mean(REG_MEAN_BLUE, 16'sh7FFF);
        random_phase(170);

        $display("Covered %0d pixel requests and %0d results over four mean settings,",
                 requests_sent, results_seen);
        $display("with stalls on both sides and one long result hold-off.");
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/ppa_pkg.sv
hdl/ppa_in_if.sv
hdl/ppa_out_if.sv
hdl/ppa_gamma_pipe.sv
hdl/photometric_pixel_augment_unit.sv
sim/photometric_pixel_augment_unit_test.sv
